FILE: sv/npc_pkg.sv
// Shared types and constants for the nearest palette color block.
// No dependencies; compiled first.
package npc_pkg;

	localparam int PALETTE_SIZE_DEF = 16;

	localparam int COMP_W  = 8;
	localparam int INDEX_W = 4;
	localparam int SQ_W    = 2 * COMP_W;
	localparam int DIST_W  = 20;

	// Larger than any reachable distance, so the first entry always wins.
	localparam logic [DIST_W-1:0] DIST_INIT = '1;

	// Red sum below this means the mean red is below 128.
	localparam logic [COMP_W+1:0] RED_SUM_LIMIT = 10'd256;

	localparam logic REQ_WRITE    = 1'b0;
	localparam logic REQ_CLASSIFY = 1'b1;

	// One transaction on its way down the chain of cells.
	typedef struct packed {
		logic                 vld;
		logic                 is_wr;
		logic [INDEX_W-1:0]   idx;
		logic [COMP_W-1:0]    red;
		logic [COMP_W-1:0]    green;
		logic [COMP_W-1:0]    blue;
		logic [DIST_W-1:0]    best_dist;
	} npc_item_t;

endpackage

FILE: sv/npc_req_if.sv
// Request channel: palette writes and pixels to classify.
// Depends on npc_pkg.
interface npc_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [npc_pkg::INDEX_W-1:0] entry_index;
	logic [npc_pkg::COMP_W-1:0]  red;
	logic [npc_pkg::COMP_W-1:0]  green;
	logic [npc_pkg::COMP_W-1:0]  blue;

	modport source (output valid, req_type, entry_index, red, green, blue, input ready);
	modport sink (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

FILE: sv/npc_res_if.sv
// Result channel: index of the nearest palette entry.
// Depends on npc_pkg.
interface npc_res_if;
	logic                        valid;
	logic                        ready;
	logic [npc_pkg::INDEX_W-1:0] color_index;

	modport source (output valid, color_index, input ready);
	modport sink (input valid, color_index, output ready);
endinterface

FILE: sv/npc_cell.sv
// One cell of the classifier chain: holds one palette entry and scores
// each passing pixel against it in two stages. Depends on npc_pkg.
module npc_cell #(
	parameter int CELL_IDX = 0,
	parameter int IDX_W    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  npc_pkg::npc_item_t item_i,
	input  logic [IDX_W-1:0]   best_idx_i,
	output npc_pkg::npc_item_t item_o,
	output logic [IDX_W-1:0]   best_idx_o
);
	import npc_pkg::*;

	logic [COMP_W-1:0] ent_red_q, ent_green_q, ent_blue_q;

	npc_item_t         item_s1, item_s2;
	logic [IDX_W-1:0]  best_idx_s1, best_idx_s2;
	logic [SQ_W-1:0]   sqr_s1, sqg_s1, sqb_s1;
	logic              low_s1;

	logic              hit;
	logic [SQ_W-1:0]   sqr, sqg, sqb;
	logic [COMP_W+1:0] red_sum;
	logic [DIST_W-1:0] wr_d, wg_d, wb_d, score;
	logic              take;
	npc_item_t         item_nx;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
			input logic [COMP_W-1:0] b);
		logic [COMP_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	assign hit = en && item_i.vld && item_i.is_wr && (32'(item_i.idx) == CELL_IDX);

	// Load the entry when a write transaction addressed to this cell passes.
	always_ff @(posedge clk) begin
		if (hit) begin
			ent_red_q   <= item_i.red;
			ent_green_q <= item_i.green;
			ent_blue_q  <= item_i.blue;
		end
	end

	assign sqr     = sq_diff(item_i.red, ent_red_q);
	assign sqg     = sq_diff(item_i.green, ent_green_q);
	assign sqb     = sq_diff(item_i.blue, ent_blue_q);
	assign red_sum = {2'b00, item_i.red} + {2'b00, ent_red_q};

	// Stage 1: squared differences and the red-mean weight select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1.vld <= 1'b0;
		end else if (en) begin
			item_s1     <= item_i;
			best_idx_s1 <= best_idx_i;
			sqr_s1      <= sqr;
			sqg_s1      <= sqg;
			sqb_s1      <= sqb;
			low_s1      <= (red_sum < RED_SUM_LIMIT);
		end
	end

	// Stage 2: weighted sum, then keep the better of this entry and the best so far.
	assign wr_d = low_s1 ? (DIST_W'(sqr_s1) << 1) : (DIST_W'(sqr_s1) + (DIST_W'(sqr_s1) << 1));
	assign wg_d = DIST_W'(sqg_s1) << 2;
	assign wb_d = low_s1 ? (DIST_W'(sqb_s1) + (DIST_W'(sqb_s1) << 1)) : (DIST_W'(sqb_s1) << 1);
	assign score = wr_d + wg_d + wb_d;
	assign take  = (score < item_s1.best_dist);

	always_comb begin
		item_nx           = item_s1;
		item_nx.best_dist = take ? score : item_s1.best_dist;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2.vld <= 1'b0;
		end else if (en) begin
			item_s2     <= item_nx;
			best_idx_s2 <= take ? IDX_W'(CELL_IDX) : best_idx_s1;
		end
	end

	assign item_o     = item_s2;
	assign best_idx_o = best_idx_s2;

endmodule

FILE: sv/nearest_palette_color.sv
// Nearest palette color: a chain of PALETTE_SIZE cells, two stages each, plus an output register.
// Throughput: one transaction per cycle; the whole chain advances together and
// holds only while the output register is full and not taken.
// Reset clears all valid bits; palette entries are undefined until written.
// Depends on npc_pkg, npc_req_if, npc_res_if and npc_cell.
module nearest_palette_color #(
	parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	npc_req_if.sink   req,
	npc_res_if.source res
);
	import npc_pkg::*;

	localparam int IDX_W = $clog2(PALETTE_SIZE);

	// Chain taps: tap k feeds cell k, the last tap leaves the chain.
	npc_item_t        chain [0:PALETTE_SIZE];
	logic [IDX_W-1:0] bidx  [0:PALETTE_SIZE];

	npc_item_t          head;
	logic               en;
	logic               out_valid_q;
	logic [INDEX_W-1:0] color_index_q;
	logic [IDX_W+INDEX_W-1:0] idx_ext;

	// Advance everything unless a finished result still waits at the output.
	assign en        = !out_valid_q || res.ready;
	assign req.ready = en;

	// Build the transaction entering the chain; distance starts above any real one.
	always_comb begin
		head.vld       = req.valid;
		head.is_wr     = (req.req_type == REQ_WRITE);
		head.idx       = req.entry_index;
		head.red       = req.red;
		head.green     = req.green;
		head.blue      = req.blue;
		head.best_dist = DIST_INIT;
	end
	assign chain[0] = head;
	assign bidx[0]  = '0;

	// Writes and pixels travel in order, so a pixel sees exactly the entries
	// written before it and none written after it.
	for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
		npc_cell #(
			.CELL_IDX (k),
			.IDX_W    (IDX_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.item_i     (chain[k]),
			.best_idx_i (bidx[k]),
			.item_o     (chain[k+1]),
			.best_idx_o (bidx[k+1])
		);
	end

	// Only the low four bits of the winner reach the result field.
	assign idx_ext = {{INDEX_W{1'b0}}, bidx[PALETTE_SIZE]};

	// Output register: drop write transactions, hold a result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain[PALETTE_SIZE].vld && !chain[PALETTE_SIZE].is_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_index_q <= idx_ext[INDEX_W-1:0];
		end
	end

	assign res.valid       = out_valid_q;
	assign res.color_index = color_index_q;

`ifndef SYNTHESIS
	a_stall_holds_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain[PALETTE_SIZE]) && $stable(bidx[PALETTE_SIZE]))
		else $error("chain tail moved while stalled");

	a_rise_needs_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(en) && $past(chain[PALETTE_SIZE].vld)
			&& !$past(chain[PALETTE_SIZE].is_wr))
		else $error("result appeared without a classify transaction leaving the chain");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (32'(res.color_index) < PALETTE_SIZE) || (PALETTE_SIZE > 16))
		else $error("color index beyond palette");
`endif

endmodule

FILE: bench/palette_match_checker.sv
`timescale 1ns / 100ps
// Checker for nearest_palette_color: shadows the palette, predicts the winning
// index of every classified pixel and compares it with the result channel.
// Depends on npc_pkg, npc_req_if and npc_res_if.
module palette_match_checker (
	input  logic clk,
	input  logic arst_n,
	npc_req_if   req,
	npc_res_if   res,
	output int   outstanding,
	output int   failures
);
	import npc_pkg::*;

	logic [COMP_W-1:0]  pal_red   [PALETTE_SIZE_DEF];
	logic [COMP_W-1:0]  pal_green [PALETTE_SIZE_DEF];
	logic [COMP_W-1:0]  pal_blue  [PALETTE_SIZE_DEF];
	logic [INDEX_W-1:0] due_index [$];
	logic [INDEX_W-1:0] want;
	int                 err_total = 0;

	// Redmean-weighted squared distance from a pixel to palette entry k.
	function automatic int weighted_gap(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
			input logic [COMP_W-1:0] b, input int k);
		int dr;
		int dg;
		int db;
		dr = int'(r) - int'(pal_red[k]);
		dg = int'(g) - int'(pal_green[k]);
		db = int'(b) - int'(pal_blue[k]);
		if ({2'b00, r} + {2'b00, pal_red[k]} < RED_SUM_LIMIT) begin
			return 2 * dr * dr + 4 * dg * dg + 3 * db * db;
		end
		return 3 * dr * dr + 4 * dg * dg + 2 * db * db;
	endfunction

	// Strict less-than: the lowest index keeps a tie.
	function automatic logic [INDEX_W-1:0] closest_entry(input logic [COMP_W-1:0] r,
			input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
		int                 best;
		int                 d;
		logic [INDEX_W-1:0] win;
		best = weighted_gap(r, g, b, 0);
		win  = '0;
		for (int k = 1; k < PALETTE_SIZE_DEF; k++) begin
			d = weighted_gap(r, g, b, k);
			if (d < best) begin
				best = d;
				win  = INDEX_W'(k);
			end
		end
		return win;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (due_index.size() == 0) begin
					$error("color_index: expected none, actual %0d", res.color_index);
					err_total++;
				end else begin
					want = due_index.pop_front();
					if (res.color_index !== want) begin
						$error("color_index: expected %0d, actual %0d", want, res.color_index);
						err_total++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_WRITE) begin
					// drop writes past the end of the palette
					if (req.entry_index < PALETTE_SIZE_DEF) begin
						pal_red[req.entry_index]   = req.red;
						pal_green[req.entry_index] = req.green;
						pal_blue[req.entry_index]  = req.blue;
					end
				end else begin
					due_index.push_back(closest_entry(req.red, req.green, req.blue));
				end
			end
			outstanding <= due_index.size();
			failures    <= err_total;
		end
	end

endmodule

FILE: bench/tb_nearest_palette_color.sv
`timescale 1ns / 100ps
// Top of the nearest_palette_color bench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on npc_pkg, both channel
// interfaces, the block itself and palette_match_checker.
module tb_nearest_palette_color;
	import npc_pkg::*;

	// Random transactions after the directed opening.
	localparam int RANDOM_ITEMS  = 1430;
	// Drain margin: the chain is two stages per cell plus the output register.
	localparam int SETTLE_CYCLES = 2 * PALETTE_SIZE_DEF + 8;

	logic clk;
	logic arst_n;
	logic no_gaps;
	int   outstanding;
	int   failures;

	// Copy of what has been written, used to aim pixels at entries and to copy one entry into another.
	logic [COMP_W-1:0] shade_red   [PALETTE_SIZE_DEF];
	logic [COMP_W-1:0] shade_green [PALETTE_SIZE_DEF];
	logic [COMP_W-1:0] shade_blue  [PALETTE_SIZE_DEF];

	npc_req_if req ();
	npc_res_if res ();

	nearest_palette_color #(
		.PALETTE_SIZE(PALETTE_SIZE_DEF)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	palette_match_checker match_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.res         (res),
		.outstanding (outstanding),
		.failures    (failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Stall the result side with a chance of about 38 in a hundred, except in the steady stretch.
	always @(posedge clk) begin
		res.ready <= no_gaps || ($urandom_range(99) >= 38);
	end

	// Offset a component by up to +/- span and clamp it to the 8-bit range.
	function automatic logic [COMP_W-1:0] jitter(input logic [COMP_W-1:0] c, input int span);
		int v;
		v = int'(c) + int'($urandom_range(2 * span)) - span;
		if (v < 0) begin
			v = 0;
		end else if (v > 255) begin
			v = 255;
		end
		return COMP_W'(v);
	endfunction

	// Present one transaction after a random number of idle cycles and hold it until taken.
	task automatic push_item(input logic kind, input logic [INDEX_W-1:0] idx,
			input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
		while (!no_gaps && $urandom_range(99) < 38) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.req_type    <= kind;
		req.entry_index <= idx;
		req.red         <= r;
		req.green       <= g;
		req.blue        <= b;
		do @(posedge clk); while (!req.ready);
		if (kind == REQ_WRITE) begin
			shade_red[idx]   = r;
			shade_green[idx] = g;
			shade_blue[idx]  = b;
		end
	endtask

	task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [COMP_W-1:0] r,
			input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
		push_item(REQ_WRITE, idx, r, g, b);
	endtask

	// The index field is unused on a classify; scramble it anyway.
	task automatic classify(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
			input logic [COMP_W-1:0] b);
		push_item(REQ_CLASSIFY, INDEX_W'($urandom_range(15)), r, g, b);
	endtask

	initial begin
		int                sent;
		int                roll;
		int                j;
		int                k;
		int                v;
		logic [COMP_W-1:0] br;
		logic [COMP_W-1:0] bg;
		logic [COMP_W-1:0] bb;

		// Hold every request input at a known value through reset.
		arst_n          = 1'b0;
		no_gaps         = 1'b0;
		req.valid       = 1'b0;
		req.req_type    = REQ_WRITE;
		req.entry_index = '0;
		req.red         = '0;
		req.green       = '0;
		req.blue        = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the whole palette before the first pixel: corners of the cube,
		// a duplicate of pure red for the tie rule, and greys on both sides
		// of the red-mean threshold.
		write_entry(4'd0, 8'd0, 8'd0, 8'd0);
		write_entry(4'd15, 8'd255, 8'd255, 8'd255);
		write_entry(4'd1, 8'd255, 8'd0, 8'd0);
		write_entry(4'd2, 8'd0, 8'd255, 8'd0);
		write_entry(4'd3, 8'd0, 8'd0, 8'd255);
		write_entry(4'd4, 8'd255, 8'd0, 8'd0);
		write_entry(4'd5, 8'd128, 8'd128, 8'd128);
		write_entry(4'd6, 8'd127, 8'd127, 8'd127);
		write_entry(4'd7, 8'd255, 8'd255, 8'd0);
		write_entry(4'd8, 8'd0, 8'd255, 8'd255);
		write_entry(4'd9, 8'd255, 8'd0, 8'd255);
		write_entry(4'd10, 8'd64, 8'd32, 8'd200);
		write_entry(4'd11, 8'd200, 8'd100, 8'd50);
		write_entry(4'd12, 8'd1, 8'd2, 8'd3);
		write_entry(4'd13, 8'd254, 8'd253, 8'd252);
		write_entry(4'd14, 8'd128, 8'd0, 8'd0);

		classify(8'd0, 8'd0, 8'd0);
		classify(8'd255, 8'd255, 8'd255);
		classify(8'd255, 8'd0, 8'd0);       // exact tie between two entries
		classify(8'd128, 8'd128, 8'd128);
		classify(8'd127, 8'd127, 8'd127);
		classify(8'd128, 8'd64, 8'd64);     // red sum lands on the threshold
		classify(8'd127, 8'd64, 8'd64);     // one below it
		classify(8'd200, 8'd180, 8'd10);

		// Random traffic: mostly pixels, some single rewrites, now and then a
		// clustered reload so distances sit close together and ties appear.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			no_gaps <= (sent >= 500 && sent < 800);
			roll = $urandom_range(99);
			if (roll < 3) begin
				br = COMP_W'($urandom_range(255));
				bg = COMP_W'($urandom_range(255));
				bb = COMP_W'($urandom_range(255));
				for (k = 0; k < PALETTE_SIZE_DEF; k++) begin
					write_entry(INDEX_W'(k), jitter(br, 12), jitter(bg, 12), jitter(bb, 12));
				end
				sent += PALETTE_SIZE_DEF;
			end else if (roll < 13) begin
				k = $urandom_range(PALETTE_SIZE_DEF - 1);
				j = $urandom_range(PALETTE_SIZE_DEF - 1);
				if ($urandom_range(1) == 0) begin
					// copy another entry to force a tie
					write_entry(INDEX_W'(k), shade_red[j], shade_green[j], shade_blue[j]);
				end else begin
					write_entry(INDEX_W'(k), COMP_W'($urandom_range(255)),
						COMP_W'($urandom_range(255)), COMP_W'($urandom_range(255)));
				end
				sent++;
			end else begin
				j = $urandom_range(PALETTE_SIZE_DEF - 1);
				case ($urandom_range(3))
					0: begin
						classify(COMP_W'($urandom_range(255)), COMP_W'($urandom_range(255)),
							COMP_W'($urandom_range(255)));
					end
					1: begin
						classify(shade_red[j], shade_green[j], shade_blue[j]);
					end
					2: begin
						classify(jitter(shade_red[j], 6), jitter(shade_green[j], 6),
							jitter(shade_blue[j], 6));
					end
					default: begin
						// aim the red sum at the weighting threshold for this entry
						v = 256 - int'(shade_red[j]) - int'($urandom_range(1));
						if (v > 255) begin
							v = 255;
						end
						classify(COMP_W'(v), jitter(shade_green[j], 8), jitter(shade_blue[j], 8));
					end
				endcase
				sent++;
			end
		end

		// Release the request side and drain what is still in the chain.
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
